FILE: rtl/sri_pkg.sv
`default_nettype none

package sri_pkg;

    localparam int DIM_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 16'd1920;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 16'd1440;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_e;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    // coordinate against zero (lo) and against the rectangle bound (hi)
    typedef struct packed {
        logic lo_lt;
        logic lo_gt;
        logic hi_lt;
        logic hi_gt;
    } coord_cmp_t;

    typedef struct packed {
        coord_cmp_t x1;
        coord_cmp_t y1;
        coord_cmp_t x2;
        coord_cmp_t y2;
        logic       w_nz;
        logic       h_nz;
    } flag_t;

    typedef struct packed {
        logic neg;
        logic zero;
    } sgn_t;

    // orientation signs of the segment line against the four corners
    typedef struct packed {
        sgn_t c00;
        sgn_t c0h;
        sgn_t cw0;
        sgn_t cwh;
    } corner_t;

endpackage

`default_nettype wire

FILE: rtl/sri_seg_if.sv
`default_nettype none

interface sri_seg_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink (input valid, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface

`default_nettype wire

FILE: rtl/sri_hit_if.sv
`default_nettype none

interface sri_hit_if;
    logic valid;
    logic ready;
    logic hits_image;

    modport source (output valid, output hits_image, input ready);
    modport sink (input valid, input hits_image, output ready);
endinterface

`default_nettype wire

FILE: rtl/segment_rect_intersect_top.sv
`default_nettype none

// Segment versus image rectangle test. Each transaction on seg carries the two
// endpoints of a segment in signed fixed point (COORD_WIDTH bits, FRAC_BITS
// fractional bits); each transaction on hit returns one bit, set when an
// endpoint lies in the closed rectangle [0, W] x [0, H] or the segment crosses
// or touches one of its edges. W and H are whole pixels written through the
// cfg port (index 0 width, index 1 height, reset 1920 x 1440); write them only
// while no transaction is in flight. The pipeline takes one segment per clock
// while hit does not hold it off; a result passes through six register stages
// (input register, split multiplier partial products, split multiplier sums,
// cross-product difference, corner orientation signs, decision). Backpressure
// on hit stalls only the stages that hold data, so bubbles keep filling. The
// block keeps no state between segments apart from the two size registers and
// needs no start-up sweep.
module segment_rect_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire sri_pkg::cfg_idx_e cfg_index,
    input  wire logic [15:0]       cfg_data,
    sri_seg_if.sink                seg,
    sri_hit_if.source              hit
);
    import sri_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int DIFW = CW + 1;
    localparam int BNDW = DIM_W + FRAC_BITS;
    localparam int CMPW = ((CW > BNDW) ? CW : BNDW) + 1;
    localparam int XPW  = 2 * CW;
    localparam int SPW  = DIFW + DIM_W + 1;
    localparam int DW1  = XPW + 1;
    localparam int DW2  = SPW + FRAC_BITS + 1;
    localparam int DW   = ((DW1 > DW2) ? DW1 : DW2) + 2;

    cfg_t cfg;

    sri_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage enables, a stage loads when empty or when its successor moves
    logic en_a, en_b, en_c, en_d, en_e, en_out;
    logic v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_e_reg, hit_v_reg;

    assign en_out    = !hit_v_reg || hit.ready;
    assign en_e      = !v_e_reg || en_out;
    assign en_d      = !v_d_reg || en_e;
    assign en_c      = !v_c_reg || en_d;
    assign en_b      = !v_b_reg || en_c;
    assign en_a      = !v_a_reg || en_b;
    assign seg.ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            v_d_reg   <= 1'b0;
            v_e_reg   <= 1'b0;
            hit_v_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                v_a_reg <= seg.valid;
            if (en_b)
                v_b_reg <= v_a_reg;
            if (en_c)
                v_c_reg <= v_b_reg;
            if (en_d)
                v_d_reg <= v_c_reg;
            if (en_e)
                v_e_reg <= v_d_reg;
            if (en_out)
                hit_v_reg <= v_e_reg;
        end
    end

    // stage a: capture endpoints and direction
    logic signed [CW-1:0]   x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [DIFW-1:0] dx_next, dy_next, dx_reg, dy_reg;

    always_comb
    begin
        dx_next = $signed({seg.end_x[CW-1], seg.end_x})
                - $signed({seg.start_x[CW-1], seg.start_x});
        dy_next = $signed({seg.end_y[CW-1], seg.end_y})
                - $signed({seg.start_y[CW-1], seg.start_y});
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            x1_reg <= seg.start_x;
            y1_reg <= seg.start_y;
            x2_reg <= seg.end_x;
            y2_reg <= seg.end_y;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // stages b and c: products
    logic signed [XPW-1:0] x2y1, x1y2;
    logic signed [SPW-1:0] dxh, dyw;
    logic signed [DIM_W:0] h_op, w_op;

    assign h_op = $signed({1'b0, cfg.image_height});
    assign w_op = $signed({1'b0, cfg.image_width});

    sri_mul #(.AW(CW), .BW(CW)) u_mul_x2y1 (
        .clk (clk), .en_pp (en_b), .en_sum (en_c),
        .a (x2_reg), .b (y1_reg), .p (x2y1)
    );

    sri_mul #(.AW(CW), .BW(CW)) u_mul_x1y2 (
        .clk (clk), .en_pp (en_b), .en_sum (en_c),
        .a (x1_reg), .b (y2_reg), .p (x1y2)
    );

    sri_mul #(.AW(DIFW), .BW(DIM_W + 1)) u_mul_dxh (
        .clk (clk), .en_pp (en_b), .en_sum (en_c),
        .a (dx_reg), .b (h_op), .p (dxh)
    );

    sri_mul #(.AW(DIFW), .BW(DIM_W + 1)) u_mul_dyw (
        .clk (clk), .en_pp (en_b), .en_sum (en_c),
        .a (dy_reg), .b (w_op), .p (dyw)
    );

    // stage b: endpoint compares against zero and the bounds
    logic signed [CMPW-1:0] w_bnd, h_bnd;
    flag_t flags_next, flags_b_reg, flags_c_reg, flags_d_reg, flags_e_reg;

    function automatic coord_cmp_t cmp_coord(input logic signed [CMPW-1:0] v,
                                             input logic signed [CMPW-1:0] bnd);
        coord_cmp_t r;
        r.lo_lt = v < 0;
        r.lo_gt = v > 0;
        r.hi_lt = v < bnd;
        r.hi_gt = v > bnd;
        return r;
    endfunction

    always_comb
    begin
        w_bnd = $signed(CMPW'(cfg.image_width) << FRAC_BITS);
        h_bnd = $signed(CMPW'(cfg.image_height) << FRAC_BITS);
        flags_next.x1   = cmp_coord(CMPW'(x1_reg), w_bnd);
        flags_next.y1   = cmp_coord(CMPW'(y1_reg), h_bnd);
        flags_next.x2   = cmp_coord(CMPW'(x2_reg), w_bnd);
        flags_next.y2   = cmp_coord(CMPW'(y2_reg), h_bnd);
        flags_next.w_nz = cfg.image_width != '0;
        flags_next.h_nz = cfg.image_height != '0;
    end

    // stage d: cross product of the endpoints and scaled edge products
    logic signed [DW-1:0] k_next, p_next, q_next, k_reg, p_reg, q_reg;

    always_comb
    begin
        k_next = DW'(x2y1) - DW'(x1y2);
        p_next = DW'(dxh) <<< FRAC_BITS;
        q_next = DW'(dyw) <<< FRAC_BITS;
    end

    // stage e: orientation of each corner against the segment line
    logic signed [DW-1:0] d00, d0h, dw0, dwh;
    corner_t corner_next, corner_reg;

    always_comb
    begin
        d00 = -k_reg;
        d0h = p_reg - k_reg;
        dw0 = -q_reg - k_reg;
        dwh = p_reg - q_reg - k_reg;
        corner_next.c00.neg  = d00[DW-1];
        corner_next.c00.zero = d00 == '0;
        corner_next.c0h.neg  = d0h[DW-1];
        corner_next.c0h.zero = d0h == '0;
        corner_next.cw0.neg  = dw0[DW-1];
        corner_next.cw0.zero = dw0 == '0;
        corner_next.cwh.neg  = dwh[DW-1];
        corner_next.cwh.zero = dwh == '0;
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
            flags_b_reg <= flags_next;
        if (en_c)
            flags_c_reg <= flags_b_reg;
        if (en_d)
        begin
            flags_d_reg <= flags_c_reg;
            k_reg       <= k_next;
            p_reg       <= p_next;
            q_reg       <= q_next;
        end
        if (en_e)
        begin
            flags_e_reg <= flags_d_reg;
            corner_reg  <= corner_next;
        end
    end

    // decision
    function automatic logic opposite(input sgn_t a, input sgn_t b);
        return (a.neg && !b.neg && !b.zero) || (!a.neg && !a.zero && b.neg);
    endfunction

    function automatic logic inside_rect(input coord_cmp_t x, input coord_cmp_t y);
        return !x.lo_lt && !x.hi_gt && !y.lo_lt && !y.hi_gt;
    endfunction

    logic bx0, bxw, by0, byh;
    logic cx0, cxw, cy0, cyh;
    logic touch, crossing, hit_next, hit_d_reg;

    always_comb
    begin
        bx0 = !(flags_e_reg.x1.lo_lt && flags_e_reg.x2.lo_lt)
            && !(flags_e_reg.x1.lo_gt && flags_e_reg.x2.lo_gt);
        bxw = !(flags_e_reg.x1.hi_lt && flags_e_reg.x2.hi_lt)
            && !(flags_e_reg.x1.hi_gt && flags_e_reg.x2.hi_gt);
        by0 = !(flags_e_reg.y1.lo_lt && flags_e_reg.y2.lo_lt)
            && !(flags_e_reg.y1.lo_gt && flags_e_reg.y2.lo_gt);
        byh = !(flags_e_reg.y1.hi_lt && flags_e_reg.y2.hi_lt)
            && !(flags_e_reg.y1.hi_gt && flags_e_reg.y2.hi_gt);
        cx0 = (flags_e_reg.x1.lo_lt && flags_e_reg.x2.lo_gt)
            || (flags_e_reg.x1.lo_gt && flags_e_reg.x2.lo_lt);
        cxw = (flags_e_reg.x1.hi_lt && flags_e_reg.x2.hi_gt)
            || (flags_e_reg.x1.hi_gt && flags_e_reg.x2.hi_lt);
        cy0 = (flags_e_reg.y1.lo_lt && flags_e_reg.y2.lo_gt)
            || (flags_e_reg.y1.lo_gt && flags_e_reg.y2.lo_lt);
        cyh = (flags_e_reg.y1.hi_lt && flags_e_reg.y2.hi_gt)
            || (flags_e_reg.y1.hi_gt && flags_e_reg.y2.hi_lt);
        // collinear corner lying on the segment
        touch = (corner_reg.c00.zero && bx0 && by0)
             || (corner_reg.c0h.zero && bx0 && byh)
             || (corner_reg.cw0.zero && bxw && by0)
             || (corner_reg.cwh.zero && bxw && byh);
        crossing = (opposite(corner_reg.c00, corner_reg.c0h) && flags_e_reg.h_nz && cx0)
                || (opposite(corner_reg.cw0, corner_reg.cwh) && flags_e_reg.h_nz && cxw)
                || (opposite(corner_reg.c00, corner_reg.cw0) && flags_e_reg.w_nz && cy0)
                || (opposite(corner_reg.c0h, corner_reg.cwh) && flags_e_reg.w_nz && cyh);
        hit_next = inside_rect(flags_e_reg.x1, flags_e_reg.y1)
                || inside_rect(flags_e_reg.x2, flags_e_reg.y2)
                || touch || crossing;
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
            hit_d_reg <= hit_next;
    end

    assign hit.valid      = hit_v_reg;
    assign hit.hits_image = hit_d_reg;

endmodule

`default_nettype wire

FILE: rtl/sri_cfg.sv
`default_nettype none

module sri_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire sri_pkg::cfg_idx_e   cfg_index,
    input  wire logic [15:0]         cfg_data,
    output sri_pkg::cfg_t            cfg
);
    import sri_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[DIM_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= RESET_WIDTH;
            cfg_reg.image_height <= RESET_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/sri_mul.sv
`default_nettype none

module sri_mul #(
    parameter int AW = 33,
    parameter int BW = 17
) (
    input  wire logic                  clk,
    input  wire logic                  en_pp,
    input  wire logic                  en_sum,
    input  wire logic signed [AW-1:0]  a,
    input  wire logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0]    p
);
    localparam int LA = AW / 2;
    localparam int HA = AW - LA;
    localparam int LB = BW / 2;
    localparam int HB = BW - LB;
    localparam int PW = AW + BW;

    logic signed [HA-1:0] a_hi;
    logic        [LA-1:0] a_lo;
    logic signed [HB-1:0] b_hi;
    logic        [LB-1:0] b_lo;

    logic signed [HA+HB-1:0]   pp_hh_next, pp_hh_reg;
    logic signed [HA+LB:0]     pp_hl_next, pp_hl_reg;
    logic signed [LA+HB:0]     pp_lh_next, pp_lh_reg;
    logic        [LA+LB-1:0]   pp_ll_next, pp_ll_reg;
    logic signed [PW-1:0]      p_next, p_reg;

    assign a_hi = a[AW-1:LA];
    assign a_lo = a[LA-1:0];
    assign b_hi = b[BW-1:LB];
    assign b_lo = b[LB-1:0];

    // partial products
    always_comb
    begin
        pp_hh_next = a_hi * b_hi;
        pp_hl_next = a_hi * $signed({1'b0, b_lo});
        pp_lh_next = $signed({1'b0, a_lo}) * b_hi;
        pp_ll_next = a_lo * b_lo;
    end

    always_comb
    begin
        p_next = (PW'(pp_hh_reg) <<< (LA + LB))
               + (PW'(pp_hl_reg) <<< LA)
               + (PW'(pp_lh_reg) <<< LB)
               + PW'(pp_ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_pp)
        begin
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_ll_reg <= pp_ll_next;
        end
        if (en_sum)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: sim/sri_hit_checker.sv
`timescale 1ns / 1ps

module sri_hit_checker #(
    parameter int FRAC_BITS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  sri_pkg::cfg_idx_e cfg_index,
    input  logic [15:0]       cfg_data,
    sri_seg_if                seg,
    sri_hit_if                hit,
    output int                pending_hits,
    output int                error_count
);
    import sri_pkg::*;

    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic               hits;
        int                 tag;
    } hit_expect_t;

    hit_expect_t      expected_hits[$];
    logic [DIM_W-1:0] width_px;
    logic [DIM_W-1:0] height_px;
    int               seg_count;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // sign of the cross product (b - a) x (c - a), exact at 128 bits
    function automatic int orient_sign(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       input longint cx, input longint cy);
        logic signed [127:0] dbx, dby, dcx, dcy, xprod;
        dbx   = bx - ax;
        dby   = by - ay;
        dcx   = cx - ax;
        dcy   = cy - ay;
        xprod = dbx * dcy - dby * dcx;
        if (xprod > 0)
            return 1;
        if (xprod < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit within_span(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       input longint cx, input longint cy);
        longint lo_x, hi_x, lo_y, hi_y;
        lo_x = (ax < bx) ? ax : bx;
        hi_x = (ax < bx) ? bx : ax;
        lo_y = (ay < by) ? ay : by;
        hi_y = (ay < by) ? by : ay;
        return lo_x <= cx && cx <= hi_x && lo_y <= cy && cy <= hi_y;
    endfunction

    function automatic bit segment_hits_rect(input longint x1, input longint y1,
                                             input longint x2, input longint y2,
                                             input logic [DIM_W-1:0] wd,
                                             input logic [DIM_W-1:0] ht);
        longint w, h;
        longint ax[4], ay[4], bx[4], by[4];
        int     d1, d2, d3, d4;
        bit     found;
        w     = longint'(wd) <<< FRAC_BITS;
        h     = longint'(ht) <<< FRAC_BITS;
        found = 1'b0;
        if ((x1 >= 0 && x1 <= w && y1 >= 0 && y1 <= h) ||
            (x2 >= 0 && x2 <= w && y2 >= 0 && y2 <= h))
            return 1'b1;
        // left, right, bottom, top edges
        ax = '{0, w, 0, 0};
        ay = '{0, 0, 0, h};
        bx = '{0, w, w, w};
        by = '{h, h, 0, h};
        for (int k = 0; k < 4 && !found; k++) begin
            d1 = orient_sign(x1, y1, x2, y2, ax[k], ay[k]);
            d2 = orient_sign(x1, y1, x2, y2, bx[k], by[k]);
            d3 = orient_sign(ax[k], ay[k], bx[k], by[k], x1, y1);
            d4 = orient_sign(ax[k], ay[k], bx[k], by[k], x2, y2);
            if (d1 * d2 < 0 && d3 * d4 < 0)
                found = 1'b1;
            else if ((d1 == 0 && within_span(x1, y1, x2, y2, ax[k], ay[k])) ||
                     (d2 == 0 && within_span(x1, y1, x2, y2, bx[k], by[k])) ||
                     (d3 == 0 && within_span(ax[k], ay[k], bx[k], by[k], x1, y1)) ||
                     (d4 == 0 && within_span(ax[k], ay[k], bx[k], by[k], x2, y2)))
                found = 1'b1;
        end
        return found;
    endfunction

    always @(posedge clk or negedge rst_n) begin : track
        hit_expect_t fresh;
        hit_expect_t oldest;
        if (!rst_n) begin
            width_px  = RESET_WIDTH;
            height_px = RESET_HEIGHT;
            seg_count = 0;
            expected_hits.delete();
            pending_hits = 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_px  = cfg_data;
                    CFG_IMAGE_HEIGHT: height_px = cfg_data;
                    default:          ;
                endcase
            end
            if (hit.valid && hit.ready) begin
                if (expected_hits.size() == 0)
                    report_mismatch($sformatf("result %b with no segment pending",
                                              hit.hits_image));
                else begin
                    oldest = expected_hits.pop_front();
                    if (hit.hits_image !== oldest.hits)
                        report_mismatch($sformatf(
                            {"segment %0d (%0d,%0d)-(%0d,%0d) size %0dx%0d: ",
                             "hits_image %b, expected %b"},
                            oldest.tag, oldest.sx, oldest.sy, oldest.ex, oldest.ey,
                            width_px, height_px, hit.hits_image, oldest.hits));
                end
            end
            if (seg.valid && seg.ready) begin
                fresh.sx   = seg.start_x;
                fresh.sy   = seg.start_y;
                fresh.ex   = seg.end_x;
                fresh.ey   = seg.end_y;
                fresh.tag  = seg_count;
                fresh.hits = segment_hits_rect(longint'(seg.start_x), longint'(seg.start_y),
                                               longint'(seg.end_x), longint'(seg.end_y),
                                               width_px, height_px);
                expected_hits.push_back(fresh);
                seg_count++;
            end
            pending_hits = expected_hits.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sri_pkg::*;

    localparam int     COORD_WIDTH     = 32;
    localparam int     FRAC_BITS       = 4;
    localparam int     CYCLE_LIMIT     = 300000;
    localparam int     SETTLE_CYCLES   = 12;
    localparam int     ITEMS_PER_PHASE = 120;
    localparam int     FLOOD_ITEMS     = 40;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     SIZE_PHASES     = 8;
    localparam longint COORD_MIN       = -64'sd2147483648;
    localparam longint COORD_MAX       = 64'sd2147483647;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    cfg_idx_e    cfg_index;
    logic [15:0] cfg_data;
    int          pending_hits;
    int          error_count;
    int          cycle_count = 0;
    int          hold_request = 0;
    bit          seg_burst = 1'b0;
    bit          hit_burst = 1'b0;
    bit          flood = 1'b0;
    logic [15:0] cur_w;
    logic [15:0] cur_h;
    logic [15:0] size_w [SIZE_PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd0,
                                          16'd65535, 16'd640, 16'd1, 16'd1920};
    logic [15:0] size_h [SIZE_PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd65535,
                                          16'd0, 16'd480, 16'd1, 16'd1440};

    sri_seg_if #(.COORD_WIDTH(COORD_WIDTH)) seg_ch ();
    sri_hit_if hit_ch ();

    segment_rect_intersect_top #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg_ch),
        .hit       (hit_ch)
    );

    sri_hit_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .seg          (seg_ch),
        .hit          (hit_ch),
        .pending_hits (pending_hits),
        .error_count  (error_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_hits);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int draw_gap(input bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 12));
    endfunction

    function automatic longint scaled(input logic [15:0] px);
        return longint'(px) <<< FRAC_BITS;
    endfunction

    function automatic longint rand_word();
        return longint'(int'($urandom));
    endfunction

    // half the time near the rectangle, else a random word, a value on or by its bounds, or a field extreme
    function automatic longint rand_coord(input longint bound);
        longint span;
        span = 2 * bound + 32;
        case ($urandom_range(0, 9))
            0, 1: return rand_word();
            2: begin
                case ($urandom_range(0, 3))
                    0:       return COORD_MIN;
                    1:       return COORD_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
            3, 4: begin
                case ($urandom_range(0, 5))
                    0:       return 0;
                    1:       return bound;
                    2:       return -1;
                    3:       return bound + 1;
                    4:       return 1;
                    default: return bound - 1;
                endcase
            end
            default: return longint'($urandom_range(0, 32'(2 * span))) - span;
        endcase
    endfunction

    task automatic send_segment(input longint sx, input longint sy,
                                input longint ex, input longint ey);
        int gap;
        gap = draw_gap(seg_burst || flood);
        if (gap > 0) begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= 32'(sx);
        seg_ch.start_y <= 32'(sy);
        seg_ch.end_x   <= 32'(ex);
        seg_ch.end_y   <= 32'(ey);
        do @(negedge clk); while (!seg_ch.ready);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        seg_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_hits != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_image_size(input logic [15:0] w, input logic [15:0] h);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    task automatic send_random_segment();
        longint w, h, a, b, cx, cy, dx, dy, span;
        w = scaled(cur_w);
        h = scaled(cur_h);
        if ($urandom_range(0, 39) == 0)
            seg_burst = !seg_burst;
        case ($urandom_range(0, 19))
            0, 1: send_segment(rand_word(), rand_word(), rand_word(), rand_word());
            // both endpoints on the line of one edge
            2, 3, 4: begin
                case ($urandom_range(0, 3))
                    0: begin
                        a = rand_coord(h);
                        b = rand_coord(h);
                        send_segment(0, a, 0, b);
                    end
                    1: begin
                        a = rand_coord(h);
                        b = rand_coord(h);
                        send_segment(w, a, w, b);
                    end
                    2: begin
                        a = rand_coord(w);
                        b = rand_coord(w);
                        send_segment(a, 0, b, 0);
                    end
                    default: begin
                        a = rand_coord(w);
                        b = rand_coord(w);
                        send_segment(a, h, b, h);
                    end
                endcase
            end
            // segment centered exactly on a corner
            5, 6, 7: begin
                cx   = $urandom_range(0, 1) ? w : 0;
                cy   = $urandom_range(0, 1) ? h : 0;
                span = $urandom_range(0, 1) ? 64 : w + h + 1;
                dx   = longint'($urandom_range(0, 32'(2 * span))) - span;
                dy   = longint'($urandom_range(0, 32'(2 * span))) - span;
                send_segment(cx - dx, cy - dy, cx + dx, cy + dy);
            end
            default: send_segment(rand_coord(w), rand_coord(h), rand_coord(w), rand_coord(h));
        endcase
    endtask

    task automatic run_directed();
        longint w, h;
        w = scaled(cur_w);
        h = scaled(cur_h);
        send_segment(0, 0, 0, 0);
        send_segment(w, h, w, h);
        send_segment(-1, 0, -1, 0);
        send_segment(w + 1, h, w + 1, h);
        send_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_segment(COORD_MIN, 100, COORD_MAX, 100);
        send_segment(100, COORD_MIN, 100, COORD_MAX);
        send_segment(-16, 16, 16, -16);
        send_segment(-17, 16, 16, -17);
        send_segment(-16, h - 16, 16, h + 16);
        send_segment(w - 16, -16, w + 16, 16);
        send_segment(-100, 0, w + 100, 0);
        send_segment(-200, 0, -100, 0);
        send_segment(w, h + 1, w, h + 100);
        send_segment(-1, COORD_MIN, -1, COORD_MAX);
        send_segment(w + 1, -5, w + 1, h + 5);
        send_segment(-50, h / 2, -10, h / 2);
    endtask

    initial begin : result_sink
        int gap;
        hit_ch.ready <= 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0)
                hit_burst = !hit_burst;
            gap = (hold_request > 0) ? hold_request : draw_gap(hit_burst);
            hold_request = 0;
            if (gap > 0) begin
                hit_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            hit_ch.ready <= 1'b1;
            do @(negedge clk); while (!hit_ch.valid);
            @(posedge clk);
        end
    end

    initial begin
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        seg_ch.valid   <= 1'b0;
        seg_ch.start_x <= '0;
        seg_ch.start_y <= '0;
        seg_ch.end_x   <= '0;
        seg_ch.end_y   <= '0;
        cur_w = RESET_WIDTH;
        cur_h = RESET_HEIGHT;
        size_w[6] = 16'($urandom_range(1, 65535));
        size_h[6] = 16'($urandom_range(1, 65535));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        // receiver holds off while segments keep coming so the pipeline backs up
        wait_idle();
        hold_request = HOLD_CYCLES;
        flood = 1'b1;
        repeat (FLOOD_ITEMS) send_random_segment();
        flood = 1'b0;
        repeat (ITEMS_PER_PHASE - FLOOD_ITEMS) send_random_segment();

        for (int p = 0; p < SIZE_PHASES; p++) begin
            set_image_size(size_w[p], size_h[p]);
            repeat (ITEMS_PER_PHASE) send_random_segment();
        end

        wait_idle();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: segment_rect_intersect_top.f
rtl/sri_pkg.sv
rtl/sri_seg_if.sv
rtl/sri_hit_if.sv
rtl/sri_cfg.sv
rtl/sri_mul.sv
rtl/segment_rect_intersect_top.sv
sim/sri_hit_checker.sv
sim/testbench.sv
